@@ hw/rtl/rti_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

	// field widths
	localparam int CW   = 24;   // coordinate and register width, Q12.12
	localparam int EW   = 25;   // edge and origin offset width
	localparam int PVW  = 50;   // pvec = dir x edge2
	localparam int QVW  = 51;   // qvec = tvec x edge1, and widened operand of the dot products
	localparam int PRW  = 51;   // partial product of a dot product
	localparam int DW   = 80;   // exact Q44.36 dot product
	localparam int RW   = 112;  // divider remainder and shifted divisor
	localparam int LOW  = 25;   // low slice of a split operand
	localparam int QTW  = 31;   // distance quotient magnitude below saturation
	localparam int QBW  = 17;   // barycentric quotient, up to 1.0 in Q1.16
	localparam int FRAC = 16;   // fraction bits added by the scaled divide
	localparam int DIV_STAGES = 32;
	localparam int IN_W  = 9 * CW;
	localparam int OUT_W = 72;
	localparam int DOTS  = 4;   // det, u, v, t

	// dot product slots
	localparam int DOT_DET = 0;
	localparam int DOT_U   = 1;
	localparam int DOT_V   = 2;
	localparam int DOT_T   = 3;

	// register reset values
	localparam logic [CW-1:0] DIR_Z_RESET   = 24'd4096;
	localparam logic [CW-1:0] EPSILON_RESET = 24'd1;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_EPSILON  = 3'd6
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ hw/rtl/ray_triangle_intersect_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// pipeline: 8 arithmetic stages, 32 restoring divider stages and one output register
// throughput: one triangle per cycle; the whole pipeline holds while the output
// register is full and not taken, so s_axis_tready follows that register
// reset: arst_n clears all valid bits and loads the register reset values

module ray_triangle_intersect_unit
	import rti_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	// configuration write port
	input  wire               cfg_we,
	input  wire  [2:0]        cfg_index,
	input  wire  [CW-1:0]     cfg_wdata,
	// triangle requests
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	// vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z
	input  wire  [IN_W-1:0]   s_axis_tdata,
	// results
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	// hit, distance, bary_u, bary_v, zero pad
	output logic [OUT_W-1:0]  m_axis_tdata
);

	logic en;

	// configuration registers
	logic signed [CW-1:0] org_q [3];
	logic signed [CW-1:0] dir_q [3];
	logic        [CW-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= DIR_Z_RESET;
			eps_q    <= EPSILON_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X: org_q[0] <= cfg_wdata;
				REG_ORIGIN_Y: org_q[1] <= cfg_wdata;
				REG_ORIGIN_Z: org_q[2] <= cfg_wdata;
				REG_DIR_X:    dir_q[0] <= cfg_wdata;
				REG_DIR_Y:    dir_q[1] <= cfg_wdata;
				REG_DIR_Z:    dir_q[2] <= cfg_wdata;
				REG_EPSILON:  eps_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advances whenever the output register can take a result
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic div_vld_sd [DIV_STAGES+1];
	logic vld_s41;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s41 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s41 <= div_vld_sd[DIV_STAGES];
		end
	end

	// unpack vertices
	logic signed [CW-1:0] vin [9];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			vin[k] = s_axis_tdata[k*CW +: CW];
		end
	end

	// stage 1: edges and origin offset
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [EW-1:0] tv_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(vin[3+i]) - EW'(vin[i]);
				e2_s1[i] <= EW'(vin[6+i]) - EW'(vin[i]);
				tv_s1[i] <= EW'(org_q[i]) - EW'(vin[i]);
			end
		end
	end

	// stage 2: cross product terms
	logic signed [PVW-2:0] pma_s2 [3];
	logic signed [PVW-2:0] pmb_s2 [3];
	logic signed [QVW-2:0] qma_s2 [3];
	logic signed [QVW-2:0] qmb_s2 [3];
	logic signed [EW-1:0]  e1_s2 [3];
	logic signed [EW-1:0]  e2_s2 [3];
	logic signed [EW-1:0]  tv_s2 [3];

	for (genvar i = 0; i < 3; i++) begin : g_cross
		localparam int IA = (i + 1) % 3;
		localparam int IB = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				pma_s2[i] <= dir_q[IA] * e2_s1[IB];
				pmb_s2[i] <= dir_q[IB] * e2_s1[IA];
				qma_s2[i] <= tv_s1[IA] * e1_s1[IB];
				qmb_s2[i] <= tv_s1[IB] * e1_s1[IA];
				e1_s2[i]  <= e1_s1[i];
				e2_s2[i]  <= e2_s1[i];
				tv_s2[i]  <= tv_s1[i];
			end
		end
	end

	// stage 3: pvec and qvec
	logic signed [PVW-1:0] pvec_s3 [3];
	logic signed [QVW-1:0] qvec_s3 [3];
	logic signed [EW-1:0]  e1_s3 [3];
	logic signed [EW-1:0]  e2_s3 [3];
	logic signed [EW-1:0]  tv_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pvec_s3[i] <= PVW'(pma_s2[i]) - PVW'(pmb_s2[i]);
				qvec_s3[i] <= QVW'(qma_s2[i]) - QVW'(qmb_s2[i]);
				e1_s3[i]   <= e1_s2[i];
				e2_s3[i]   <= e2_s2[i];
				tv_s3[i]   <= tv_s2[i];
			end
		end
	end

	// operands of the four dot products, the wide side split in two slices
	logic signed [EW-1:0]  opa [DOTS][3];
	logic signed [QVW-1:0] opb [DOTS][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			opa[DOT_DET][i] = e1_s3[i];
			opb[DOT_DET][i] = QVW'(pvec_s3[i]);
			opa[DOT_U][i]   = tv_s3[i];
			opb[DOT_U][i]   = QVW'(pvec_s3[i]);
			opa[DOT_V][i]   = EW'(dir_q[i]);
			opb[DOT_V][i]   = qvec_s3[i];
			opa[DOT_T][i]   = e2_s3[i];
			opb[DOT_T][i]   = qvec_s3[i];
		end
	end

	// stage 4: partial products
	logic signed [PRW-1:0] prl_s4 [DOTS][3];
	logic signed [PRW-1:0] prh_s4 [DOTS][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < DOTS; d++) begin
				for (int i = 0; i < 3; i++) begin
					prl_s4[d][i] <= opa[d][i] * $signed({1'b0, opb[d][i][LOW-1:0]});
					prh_s4[d][i] <= opa[d][i] * $signed(opb[d][i][QVW-1:LOW]);
				end
			end
		end
	end

	// stage 5: recombine slices
	logic signed [DW-1:0] term_s5 [DOTS][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < DOTS; d++) begin
				for (int i = 0; i < 3; i++) begin
					term_s5[d][i] <= (DW'(prh_s4[d][i]) <<< LOW) + DW'(prl_s4[d][i]);
				end
			end
		end
	end

	// stage 6: sum the three terms
	logic signed [DW-1:0] dot_s6 [DOTS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < DOTS; d++) begin
				dot_s6[d] <= term_s5[d][0] + term_s5[d][1] + term_s5[d][2];
			end
		end
	end

	// stage 7: fold the sign so det is nonnegative
	logic                 pos_det;
	logic signed [DW-1:0] det_s7, u_s7, v_s7, t_s7;

	assign pos_det = dot_s6[DOT_DET] > 0;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s7 <= pos_det ? dot_s6[DOT_DET] : -dot_s6[DOT_DET];
			u_s7   <= pos_det ? dot_s6[DOT_U]   : -dot_s6[DOT_U];
			v_s7   <= pos_det ? dot_s6[DOT_V]   : -dot_s6[DOT_V];
			t_s7   <= pos_det ? dot_s6[DOT_T]   : -dot_s6[DOT_T];
		end
	end

	// stage 8: rejection tests
	logic signed [DW-1:0] eps_wide;
	logic signed [DW-1:0] uv_sum;
	logic                 miss;
	logic                 hit_s8, tneg_s8;
	logic [DW-1:0]        det_s8, u_s8, v_s8, tmag_s8;

	assign eps_wide = $signed({{(DW-2*CW){1'b0}}, eps_q, {CW{1'b0}}});
	assign uv_sum   = u_s7 + v_s7;
	assign miss     = (det_s7 == 0) || (det_s7 < eps_wide) || (u_s7 < 0) ||
		(u_s7 > det_s7) || (v_s7 < 0) || (uv_sum > det_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s8  <= !miss;
			tneg_s8 <= t_s7 < 0;
			det_s8  <= det_s7;
			u_s8    <= u_s7;
			v_s8    <= v_s7;
			tmag_s8 <= (t_s7 < 0) ? -t_s7 : t_s7;
		end
	end

	// divider stages 9 to 40, one quotient bit each; slot 0 holds the stage 8 values
	logic            div_hit_sd  [DIV_STAGES+1];
	logic            div_tneg_sd [DIV_STAGES+1];
	logic            div_sat_sd  [DIV_STAGES+1];
	logic [DW-1:0]   div_den_sd  [DIV_STAGES+1];
	logic [RW-1:0]   div_rt_sd   [DIV_STAGES+1];
	logic [RW-1:0]   div_ru_sd   [DIV_STAGES+1];
	logic [RW-1:0]   div_rv_sd   [DIV_STAGES+1];
	logic [QTW-1:0]  div_qt_sd   [DIV_STAGES+1];
	logic [QBW-1:0]  div_qu_sd   [DIV_STAGES+1];
	logic [QBW-1:0]  div_qv_sd   [DIV_STAGES+1];

	assign div_vld_sd[0]  = vld_s8;
	assign div_hit_sd[0]  = hit_s8;
	assign div_tneg_sd[0] = tneg_s8;
	assign div_sat_sd[0]  = 1'b0;
	assign div_den_sd[0]  = det_s8;
	assign div_rt_sd[0]   = RW'(tmag_s8) << FRAC;
	assign div_ru_sd[0]   = RW'(u_s8) << FRAC;
	assign div_rv_sd[0]   = RW'(v_s8) << FRAC;
	assign div_qt_sd[0]   = '0;
	assign div_qu_sd[0]   = '0;
	assign div_qv_sd[0]   = '0;

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		localparam int K = DIV_STAGES - 1 - j;
		logic [RW-1:0] dsh;
		logic          ct, cu, cv;

		assign dsh = RW'(div_den_sd[j]) << K;
		assign ct  = div_rt_sd[j] >= dsh;
		assign cu  = div_ru_sd[j] >= dsh;
		assign cv  = div_rv_sd[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_sd[j+1] <= 1'b0;
			end else if (en) begin
				div_vld_sd[j+1] <= div_vld_sd[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_hit_sd[j+1]  <= div_hit_sd[j];
				div_tneg_sd[j+1] <= div_tneg_sd[j];
				div_den_sd[j+1]  <= div_den_sd[j];
				div_rt_sd[j+1]   <= ct ? div_rt_sd[j] - dsh : div_rt_sd[j];
			end
		end

		// top bit only flags a distance beyond the Q16.16 range
		if (K == QTW) begin : g_sat
			always_ff @(posedge clk) begin
				if (en) begin
					div_sat_sd[j+1] <= ct;
					div_qt_sd[j+1]  <= div_qt_sd[j];
				end
			end
		end else begin : g_qt
			always_ff @(posedge clk) begin
				if (en) begin
					div_sat_sd[j+1] <= div_sat_sd[j];
					div_qt_sd[j+1]  <= div_qt_sd[j] | (QTW'(ct) << K);
				end
			end
		end

		// barycentric quotients only have their low bits
		if (K < QBW) begin : g_bary
			always_ff @(posedge clk) begin
				if (en) begin
					div_ru_sd[j+1] <= cu ? div_ru_sd[j] - dsh : div_ru_sd[j];
					div_rv_sd[j+1] <= cv ? div_rv_sd[j] - dsh : div_rv_sd[j];
					div_qu_sd[j+1] <= div_qu_sd[j] | (QBW'(cu) << K);
					div_qv_sd[j+1] <= div_qv_sd[j] | (QBW'(cv) << K);
				end
			end
		end else begin : g_bary_wait
			always_ff @(posedge clk) begin
				if (en) begin
					div_ru_sd[j+1] <= div_ru_sd[j];
					div_rv_sd[j+1] <= div_rv_sd[j];
					div_qu_sd[j+1] <= div_qu_sd[j];
					div_qv_sd[j+1] <= div_qv_sd[j];
				end
			end
		end
	end

	// distance sign and saturation
	logic        [31:0] dist_nx;
	logic        [31:0] qt_ext;

	assign qt_ext = {1'b0, div_qt_sd[DIV_STAGES]};

	always_comb begin
		if (div_sat_sd[DIV_STAGES]) begin
			dist_nx = div_tneg_sd[DIV_STAGES] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			dist_nx = div_tneg_sd[DIV_STAGES] ? -qt_ext : qt_ext;
		end
	end

	// stage 41: output register, fields zero on a miss
	logic        hit_s41;
	logic [31:0] dist_s41;
	logic [QBW-1:0] bu_s41, bv_s41;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s41  <= div_hit_sd[DIV_STAGES];
			dist_s41 <= div_hit_sd[DIV_STAGES] ? dist_nx : '0;
			bu_s41   <= div_hit_sd[DIV_STAGES] ? div_qu_sd[DIV_STAGES] : '0;
			bv_s41   <= div_hit_sd[DIV_STAGES] ? div_qv_sd[DIV_STAGES] : '0;
		end
	end

	assign m_axis_tvalid = vld_s41;
	assign m_axis_tdata  = {5'b0, bv_s41, bu_s41, dist_s41, hit_s41};

`ifndef SYNTHESIS
	// a miss carries no distance or barycentrics
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[66:1] == 66'd0)
		else $error("miss result with nonzero fields");

	// barycentrics of a hit never sum past one
	a_bary_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ({1'b0, m_axis_tdata[49:33]} + {1'b0, m_axis_tdata[66:50]})
		<= 18'd65536)
		else $error("barycentric sum above one");

	// requests are refused only while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("request refused without a waiting result");

	// a held result stays valid and keeps its hit flag in the next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(hit_s41))
		else $error("held result lost");
`endif

endmodule

`default_nettype wire
